// ----- hdl/qdq_pkg.sv -----
// Shared types, sizes and codes for the multi-queue urgent-front deque.
`timescale 1ns / 1ps
package qdq_pkg;

   localparam int NUM_QUEUES  = 32;
   localparam int QUEUE_DEPTH = 8;
   localparam int TAG_BITS    = 16;

   localparam int QADDR_BITS = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Field widths on the stream ports.
   localparam int QIDX_W   = 5;
   localparam int TAG_W    = 16;
   localparam int COUNT_W  = 4;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   typedef enum logic [1:0] {
      STAT_ADDED = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_TAKEN = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                urgent;
   } entry_type;

   // Slot 0 of a row is the head of the queue.
   typedef entry_type [QUEUE_DEPTH-1:0] row_type;

   typedef struct packed {
      row_type              row;
      logic [CNT_BITS-1:0]  count;
      logic                 write;
      status_type           status;
      entry_type            head;
   } update_type;

endpackage

// ----- hdl/qdq_row_mem.sv -----
// Row store: one wide word per queue holding all of its slots.
`timescale 1ns / 1ps
module qdq_row_mem (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [qdq_pkg::QADDR_BITS-1:0] rd_addr,
   output qdq_pkg::row_type              rd_data,
   input  logic                          wr_en,
   input  logic [qdq_pkg::QADDR_BITS-1:0] wr_addr,
   input  qdq_pkg::row_type              wr_data
);

   qdq_pkg::row_type mem [qdq_pkg::NUM_QUEUES];
   qdq_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/qdq_count_mem.sv -----
// Per-queue fill counts; a queue never written reads as empty.
`timescale 1ns / 1ps
module qdq_count_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [qdq_pkg::QADDR_BITS-1:0] rd_addr,
   output logic [qdq_pkg::CNT_BITS-1:0]   rd_data,
   input  logic                          wr_en,
   input  logic [qdq_pkg::QADDR_BITS-1:0] wr_addr,
   input  logic [qdq_pkg::CNT_BITS-1:0]   wr_data
);

   logic [qdq_pkg::CNT_BITS-1:0]   mem [qdq_pkg::NUM_QUEUES];
   logic [qdq_pkg::NUM_QUEUES-1:0] valid_ff;
   logic [qdq_pkg::CNT_BITS-1:0]   rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/qdq_shift.sv -----
// Row update: front insert, tail append or head removal with shift.
`timescale 1ns / 1ps
module qdq_shift (
   input  logic                        op,
   input  logic                        in_range,
   input  logic [qdq_pkg::TAG_BITS-1:0] tag,
   input  logic                        urgent,
   input  logic [qdq_pkg::CNT_BITS-1:0] count,
   input  qdq_pkg::row_type            row,
   output qdq_pkg::update_type         upd
);

   qdq_pkg::entry_type new_entry;
   logic               full;
   logic               empty;

   always_comb begin
      new_entry.tag    = tag;
      new_entry.urgent = urgent;
      full  = (count >= qdq_pkg::CNT_BITS'(qdq_pkg::QUEUE_DEPTH));
      empty = (count == '0);

      upd.row    = row;
      upd.count  = count;
      upd.write  = 1'b0;
      upd.status = qdq_pkg::STAT_EMPTY;
      upd.head   = '0;

      if (!in_range) begin
         upd.count  = '0;
         upd.status = (op == qdq_pkg::OP_ADD) ? qdq_pkg::STAT_FULL : qdq_pkg::STAT_EMPTY;
      end else if (op == qdq_pkg::OP_ADD) begin
         if (full) begin
            upd.status = qdq_pkg::STAT_FULL;
         end else begin
            upd.status = qdq_pkg::STAT_ADDED;
            upd.write  = 1'b1;
            upd.count  = count + 1'b1;
            if (urgent) begin
               // everyone moves back one slot, newcomer takes the head
               upd.row[0] = new_entry;
               for (int k = 1; k < qdq_pkg::QUEUE_DEPTH; k++) begin
                  upd.row[k] = row[k-1];
               end
            end else begin
               for (int k = 0; k < qdq_pkg::QUEUE_DEPTH; k++) begin
                  if (qdq_pkg::CNT_BITS'(k) == count) begin
                     upd.row[k] = new_entry;
                  end
               end
            end
         end
      end else begin
         if (empty) begin
            upd.status = qdq_pkg::STAT_EMPTY;
         end else begin
            upd.status = qdq_pkg::STAT_TAKEN;
            upd.write  = 1'b1;
            upd.count  = count - 1'b1;
            upd.head   = row[0];
            for (int k = 0; k + 1 < qdq_pkg::QUEUE_DEPTH; k++) begin
               upd.row[k] = row[k+1];
            end
         end
      end
   end

endmodule

// ----- hdl/multi_queue_urgent_front_deque.sv -----
// Top level: bank of bounded deques with urgent front insert, stream ports.
// An accepted request beat reads the row and count memories; S_EXEC then updates
//   the row, writes it back (one read port, one write port) and registers the response.
//   Requests go one at a time: none is taken in S_EXEC or while a response stalls.
// Reset: synchronous, active high; all queues read as empty, no beat pending.
//   Slot contents are not cleared; only slots below a queue's count are read.
`timescale 1ns / 1ps
module multi_queue_urgent_front_deque (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [4:0] queue_index, [20:5] entry_tag, [21] urgent, pad
   input  logic        req_tuser,  // [0] op
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [15:0] taken_tag, [16] taken_urgent, [20:17] count_after
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;

   // captured request beat
   logic                        op_ff;
   logic [qdq_pkg::QIDX_W-1:0]  qidx_ff;
   logic [qdq_pkg::TAG_W-1:0]   tag_ff;
   logic                        urg_ff;

   // response register
   logic                        rsp_valid_ff;
   qdq_pkg::status_type         rsp_status_ff;
   logic [qdq_pkg::TAG_W-1:0]   rsp_tag_ff;
   logic                        rsp_urg_ff;
   logic [qdq_pkg::COUNT_W-1:0] rsp_cnt_ff;

   logic                        req_accept;
   logic                        in_range;
   logic [qdq_pkg::QADDR_BITS-1:0] rd_addr;
   logic [qdq_pkg::QADDR_BITS-1:0] wr_addr;
   qdq_pkg::row_type            row_rd;
   logic [qdq_pkg::CNT_BITS-1:0] cnt_rd;
   qdq_pkg::update_type         upd;
   logic                        do_write;

   // Ready only when idle and the response slot is free by the time
   // this beat's result lands.
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign rd_addr  = qdq_pkg::QADDR_BITS'(req_tdata[4:0]);
   assign wr_addr  = qdq_pkg::QADDR_BITS'(qidx_ff);
   assign in_range = (32'(qidx_ff) < 32'(qdq_pkg::NUM_QUEUES));
   assign do_write = (state_ff == S_EXEC) && upd.write;

   qdq_row_mem u_row_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (row_rd),
      .wr_en   (do_write),
      .wr_addr (wr_addr),
      .wr_data (upd.row)
   );

   qdq_count_mem u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd),
      .wr_en   (do_write),
      .wr_addr (wr_addr),
      .wr_data (upd.count)
   );

   qdq_shift u_shift (
      .op       (op_ff),
      .in_range (in_range),
      .tag      (qdq_pkg::TAG_BITS'(tag_ff)),
      .urgent   (urg_ff),
      .count    (cnt_rd),
      .row      (row_rd),
      .upd      (upd)
   );

   // capture the request beat while the memories are read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_tuser;
         qidx_ff <= req_tdata[4:0];
         tag_ff  <= req_tdata[20:5];
         urg_ff  <= req_tdata[21];
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff && rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               // row and count are back from memory: update, write back, respond
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= upd.status;
               rsp_tag_ff    <= qdq_pkg::TAG_W'(upd.head.tag);
               rsp_urg_ff    <= upd.head.urgent;
               rsp_cnt_ff    <= qdq_pkg::COUNT_W'(upd.count);
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_urg_ff, rsp_tag_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- tb/tb_multi_queue_urgent_front_deque.sv -----
// Self-checking testbench for the multi-queue urgent-front deque, directed and random beats.
`timescale 1ns / 1ps
module tb_multi_queue_urgent_front_deque;
   import qdq_pkg::*;

   // Cycles with no beat on either side before the run is declared hung.
   // Sender idles and receiver stalls are drawn per cycle at up to 80%, so a
   // quiet stretch as long as this limit is vanishingly rare.
   localparam int HANG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;   // extra slack after the last response beat
   localparam int RANDOM_PER_PHASE = 132;

   typedef struct {
      logic              op;
      logic [QIDX_W-1:0] qidx;
      logic [TAG_W-1:0]  tag;
      logic              urgent;
   } request_type;

   typedef struct {
      status_type         status;
      logic [TAG_W-1:0]   tag;
      logic               urgent;
      logic [COUNT_W-1:0] count;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [4:0] queue_index, [20:5] entry_tag, [21] urgent, pad
   logic        req_tuser = 1'b0; // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] taken_tag, [16] taken_urgent, [20:17] count_after
   logic [1:0]  rsp_tuser;        // [1:0] status

   // Shadow copy of every queue; front of each SV queue is the head slot.
   entry_type shadow_rows[NUM_QUEUES][$];
   response_type pending_results[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int beats_sent         = 0;
   int beats_checked      = 0;
   int idle_cycles        = 0;
   int status_seen[4]     = '{0, 0, 0, 0};

   multi_queue_urgent_front_deque dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Apply one request to the shadow queues and return what the block must answer.
   function automatic response_type apply_to_shadow(request_type r);
      response_type res;
      entry_type e;
      int        fill;
      res.status = STAT_ADDED;
      res.tag    = '0;
      res.urgent = 1'b0;
      fill = shadow_rows[r.qidx].size();
      if (r.op == OP_ADD) begin
         if (fill >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;         // full: nothing moves
         end else begin
            e.tag    = r.tag;
            e.urgent = r.urgent;
            // urgent goes to the head, so the newest urgent is served first
            if (r.urgent)
               shadow_rows[r.qidx].push_front(e);
            else
               shadow_rows[r.qidx].push_back(e);
         end
      end else if (fill == 0) begin
         res.status = STAT_EMPTY;
      end else begin
         e          = shadow_rows[r.qidx].pop_front();
         res.status = STAT_TAKEN;
         res.tag    = e.tag;
         res.urgent = e.urgent;
      end
      res.count = COUNT_W'(shadow_rows[r.qidx].size());
      return res;
   endfunction

   // Drive one request beat and hold it until accepted. Always entered and left
   // right after a rising edge; tvalid stays high on return so back-to-back beats
   // never drop it within a time step.
   task automatic send_request(input logic op, input int qidx, input logic [TAG_W-1:0] tag,
                               input logic urgent);
      request_type r;
      r.op     = op;
      r.qidx   = QIDX_W'(qidx);
      r.tag    = tag;
      r.urgent = urgent;
      // idle drawn per cycle, so the sender sits out about sender_idle_pct of cycles
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.urgent, r.tag, r.qidx};
      req_tuser  <= r.op;
      @(posedge clock);
      // values read here are from before the edge, so this is the handshake at this edge
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_to_shadow(r));
      beats_sent++;
   endtask

   // Empty take, fill to capacity with urgency alternating in pairs, then both
   // kinds of add against a full queue and a final take.
   task automatic test_empty_and_full();
      send_request(OP_TAKE, 0, 16'hFFFF, 1'b1);   // take on empty, tag ignored
      for (int k = 0; k < QUEUE_DEPTH; k++)
         send_request(OP_ADD, 0, (k % 2) ? 16'hFFFF : 16'h0000, k[1]);
      send_request(OP_ADD, 0, 16'h1234, 1'b0);    // rejected, full
      send_request(OP_ADD, 0, 16'h4321, 1'b1);    // urgent also rejected when full
      send_request(OP_TAKE, 0, 16'h0000, 1'b0);
   endtask

   // Mixed urgent and regular adds on the top queue: urgent entries come out
   // newest first, then the regular ones in arrival order.
   task automatic test_urgent_order();
      send_request(OP_ADD, 31, 16'h0000, 1'b0);
      send_request(OP_ADD, 31, 16'hFFFF, 1'b1);
      send_request(OP_ADD, 31, 16'h5555, 1'b1);
      send_request(OP_ADD, 31, 16'hAAAA, 1'b0);
      repeat (5) send_request(OP_TAKE, 31, 16'hFFFF, 1'b0);  // last one hits empty
   endtask

   // Traffic aimed at a few neighboring queues at a time, alternating between
   // fill-heavy and drain-heavy stretches so queues hit both full and empty.
   task automatic test_random_traffic(input int n_items);
      int   mode_left;
      bit   filling;
      int   hot_base;
      int   qidx;
      logic op;
      mode_left = 0;
      filling   = 1'b0;
      hot_base  = 0;
      for (int i = 0; i < n_items; i++) begin
         if (mode_left == 0) begin
            filling   = ~filling;
            mode_left = $urandom_range(10, 40);
            hot_base  = $urandom_range(0, NUM_QUEUES - 4);
         end
         mode_left--;
         qidx = ($urandom_range(9) == 0) ? $urandom_range(0, NUM_QUEUES - 1)
                                         : hot_base + $urandom_range(0, 3);
         if (filling)
            op = ($urandom_range(99) < 75) ? OP_ADD : OP_TAKE;
         else
            op = ($urandom_range(99) < 25) ? OP_ADD : OP_TAKE;
         send_request(op, qidx, TAG_W'($urandom), 1'($urandom_range(1)));
      end
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Response check against the oldest expectation.
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response beat tuser=%0d tdata=%h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            beats_checked++;
            status_seen[rsp_tuser]++;
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch expected %0d actual %0d",
                        $time, want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[15:0] !== want.tag) begin
               $display("%0t: taken_tag mismatch expected %h actual %h",
                        $time, want.tag, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[16] !== want.urgent) begin
               $display("%0t: taken_urgent mismatch expected %b actual %b",
                        $time, want.urgent, rsp_tdata[16]);
               error_count++;
            end
            if (rsp_tdata[20:17] !== want.count) begin
               $display("%0t: count_after mismatch expected %0d actual %0d",
                        $time, want.count, rsp_tdata[20:17]);
               error_count++;
            end
         end
      end
   end

   // Hang detector: counts cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d responses outstanding",
                  $time, HANG_LIMIT, pending_results.size());
         $display("** multi_queue_urgent_front_deque: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at full rate
      test_empty_and_full();
      test_urgent_order();

      // random part through the idling phases: none, sender, receiver, both
      sender_idle_pct = 0;  receiver_stall_pct = 0;
      test_random_traffic(RANDOM_PER_PHASE);
      sender_idle_pct = 80; receiver_stall_pct = 0;
      test_random_traffic(RANDOM_PER_PHASE);
      sender_idle_pct = 0;  receiver_stall_pct = 80;
      test_random_traffic(RANDOM_PER_PHASE);
      sender_idle_pct = 20; receiver_stall_pct = 20;
      test_random_traffic(RANDOM_PER_PHASE);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats, checked %0d responses under four idling phases.",
               beats_sent, beats_checked);
      $display("Responses: added %0d, full %0d, taken %0d, empty %0d.",
               status_seen[STAT_ADDED], status_seen[STAT_FULL],
               status_seen[STAT_TAKEN], status_seen[STAT_EMPTY]);
      if (error_count == 0) begin
         $display("** multi_queue_urgent_front_deque: PASSED **");
      end else begin
         $display("** multi_queue_urgent_front_deque: FAILED **");
      end
      $finish;
   end

endmodule
